// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Concurrent assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

// ===== hw/rtl/b64_pkg.sv =====
// Package for the base64 stream encoder: word types, character constants
// and the sextet to ASCII mapping. Depends on nothing.
package b64_pkg;

	localparam int unsigned POS_W = 17;

	localparam logic [6:0] CHAR_UPPER_A = 7'h41;
	localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;
	localparam logic [6:0] CHAR_LOWER_A = 7'h61;
	localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;
	localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
	localparam logic [6:0] CHAR_DIGIT_9 = 7'h39;
	localparam logic [6:0] CHAR_PLUS    = 7'h2B;
	localparam logic [6:0] CHAR_SLASH   = 7'h2F;

	localparam logic [5:0] SEXTET_LOWER_START = 6'd26;
	localparam logic [5:0] SEXTET_DIGIT_START = 6'd52;
	localparam logic [5:0] SEXTET_PLUS        = 6'd62;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [6:0]       char_code;
		logic [POS_W-1:0] char_position;
		logic             last_char;
	} out_word_t;

	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
		logic [6:0] code;
		if (v < SEXTET_LOWER_START) begin
			code = CHAR_UPPER_A + 7'(v);
		end else if (v < SEXTET_DIGIT_START) begin
			code = CHAR_LOWER_A + 7'(v - SEXTET_LOWER_START);
		end else if (v < SEXTET_PLUS) begin
			code = CHAR_DIGIT_0 + 7'(v - SEXTET_DIGIT_START);
		end else if (v == SEXTET_PLUS) begin
			code = CHAR_PLUS;
		end else begin
			code = CHAR_SLASH;
		end
		return code;
	endfunction

endpackage

// ===== hw/rtl/base64_unpadded_stream_encoder.sv =====
// A byte's first character is written into the registered result queue when the byte
// is taken. Throughput: one character per cycle leaves the three-word queue unless
// dst_stall is high; a byte with one character can be taken every cycle, while one
// with two fills it to two or more words; the input stalls while the queue holds
// two or more words. Reset is asynchronous and clears the byte phase, leftover bits,
// position and queue count. Depends on b64_pkg.
module base64_unpadded_stream_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  b64_pkg::in_word_t  src_word,
	output logic               dst_valid,
	input  logic               dst_stall,
	output b64_pkg::out_word_t dst_word
);
	import b64_pkg::*;

	localparam int unsigned QDEPTH = 3;

	logic [1:0]       phase_q;
	logic [3:0]       left_q;
	logic [POS_W-1:0] pos_q;
	logic [1:0]       count_q;
	out_word_t        queue_q [QDEPTH];
	out_word_t        queue_d [QDEPTH];

	logic       push, pop, two;
	logic [1:0] base;
	logic [5:0] sx0, sx1;
	logic       last1;
	logic [1:0] phase_d;
	logic [3:0] left_d;
	out_word_t  ch0, ch1;

	assign src_stall = (count_q > 2'd1);
	assign push      = src_valid && !src_stall;
	assign dst_valid = (count_q != 2'd0);
	assign pop       = dst_valid && !dst_stall;
	assign dst_word  = queue_q[0];
	assign base      = count_q - {1'b0, pop};

	always_comb begin
		sx1   = '0;
		last1 = src_word.final_byte;
		two   = src_word.final_byte;
		case (phase_q)
			2'd1: begin
				sx0     = {left_q[1:0], src_word.data_byte[7:4]};
				sx1     = {src_word.data_byte[3:0], 2'b00};
				left_d  = src_word.data_byte[3:0];
				phase_d = 2'd2;
			end
			2'd2: begin
				sx0     = {left_q, src_word.data_byte[7:6]};
				sx1     = src_word.data_byte[5:0];
				two     = 1'b1;
				left_d  = '0;
				phase_d = 2'd0;
			end
			default: begin
				sx0     = src_word.data_byte[7:2];
				sx1     = {src_word.data_byte[1:0], 4'b0000};
				left_d  = {2'b00, src_word.data_byte[1:0]};
				phase_d = 2'd1;
			end
		endcase
		ch0.char_code     = sextet_to_ascii(sx0);
		ch0.char_position = pos_q;
		ch0.last_char     = 1'b0;
		ch1.char_code     = sextet_to_ascii(sx1);
		ch1.char_position = pos_q + POS_W'(1);
		ch1.last_char     = last1;
	end

	always_comb begin
		queue_d = queue_q;
		if (pop) begin
			queue_d[0] = queue_q[1];
			queue_d[1] = queue_q[2];
		end
		if (push) begin
			queue_d[base] = ch0;
			if (two) begin
				queue_d[2'(base + 2'd1)] = ch1;
			end
		end
	end

	always_ff @(posedge clk) begin
		queue_q <= queue_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			left_q  <= '0;
			pos_q   <= '0;
			count_q <= '0;
		end else begin
			count_q <= base + (push ? {1'b0, two} + 2'd1 : 2'd0);
			if (push) begin
				if (src_word.final_byte) begin
					phase_q <= '0;
					left_q  <= '0;
					pos_q   <= '0;
				end else begin
					phase_q <= phase_d;
					left_q  <= left_d;
					pos_q   <= pos_q + (two ? POS_W'(2) : POS_W'(1));
				end
			end
		end
	end

endmodule

// ===== hw/rtl/b64_checker.sv =====
// Port-level checker for the base64 stream encoder, bound to its top level.
// Depends on b64_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b64_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input b64_pkg::in_word_t  src_word,
	input logic               dst_valid,
	input logic               dst_stall,
	input b64_pkg::out_word_t dst_word
);
	import b64_pkg::*;

	logic [6:0] code;
	logic       code_ok;

	assign code = dst_word.char_code;
	assign code_ok = (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) ||
		(code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) ||
		(code >= CHAR_DIGIT_0 && code <= CHAR_DIGIT_9) ||
		code == CHAR_PLUS || code == CHAR_SLASH;

	`ASSERT_CLKD(a_src_hold, clk, arst_n, src_valid && src_stall |=> src_valid && $stable(src_word))
	`ASSERT_CLKD(a_dst_hold, clk, arst_n, dst_valid && dst_stall |=> dst_valid && $stable(dst_word))
	`ASSERT_CLKD(a_alphabet, clk, arst_n, dst_valid |-> code_ok)
	`ASSERT_CLKD(a_empty_no_stall, clk, arst_n, !dst_valid |-> !src_stall)
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !dst_valid && !src_stall)

endmodule

bind base64_unpadded_stream_encoder b64_checker u_b64_checker (.*);
